### design/wear_level_ring_store_top_macros.svh
// assertion macros for the wear-levelled ring store
// used by modules that check their own control logic; needs clk and rst_n in scope
`ifndef WEAR_LEVEL_RING_STORE_TOP_MACROS_SVH
`define WEAR_LEVEL_RING_STORE_TOP_MACROS_SVH

// same-cycle implication
`define WLRS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WLRS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/wlrs_pkg.sv
// shared constants, types and helpers for the wear-levelled ring store
// no dependencies
package wlrs_pkg;

    localparam int DEPTH       = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int STATUS_W    = 8;
    localparam int CFG_W       = 5;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 32;
    localparam int OUT_SLOT_W  = 4;
    localparam int SLOT_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int SLOTS_RESET = 16;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef logic [SLOT_W-1:0]     slot_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [STATUS_W-1:0]   status_t;
    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [CFG_W-1:0]      cfg_t;
    typedef logic [IN_DATA_W-1:0]  in_data_t;
    typedef logic [OUT_DATA_W-1:0] out_data_t;
    typedef logic [OUT_SLOT_W-1:0] out_slot_t;

    // memory requests from the sequencer to the ring store
    typedef struct packed {
        logic    st_re;
        slot_t   st_raddr;
        logic    dt_re;
        slot_t   dt_raddr;
        logic    we;
        slot_t   waddr;
        status_t wstatus;
        word_t   wdata;
    } mem_req_t;

    // zero counts as one, anything past the built depth saturates
    function automatic cnt_t active_slots(input cfg_t cfg);
        cnt_t n;
        if (cfg == '0)
        begin
            n = cnt_t'(1);
        end
        else if (int'(cfg) > DEPTH)
        begin
            n = cnt_t'(DEPTH);
        end
        else
        begin
            n = cnt_t'(cfg);
        end
        return n;
    endfunction

endpackage

### design/wlrs_req_if.sv
// request channel of the ring store: valid/ready plus command and write word
// uses wlrs_pkg
interface wlrs_req_if;
    logic                valid;
    logic                ready;
    logic                cmd;
    wlrs_pkg::in_data_t  write_data;

    modport source (output valid, output cmd, output write_data, input ready);
    modport sink   (input valid, input cmd, input write_data, output ready);
endinterface

### design/wlrs_rsp_if.sv
// response channel of the ring store: valid/ready plus read word and slot
// uses wlrs_pkg
interface wlrs_rsp_if;
    logic                 valid;
    logic                 ready;
    wlrs_pkg::out_data_t  read_data;
    wlrs_pkg::out_slot_t  slot;

    modport source (output valid, output read_data, output slot, input ready);
    modport sink   (input valid, input read_data, input slot, output ready);
endinterface

### design/wlrs_ram.sv
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
module wlrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/wlrs_store.sv
// status ring and data ring with per-slot valid bits; unwritten slots read as zero
// depends on wlrs_pkg and wlrs_ram
module wlrs_store (
    input  logic                clk,
    input  logic                rst_n,
    input  wlrs_pkg::mem_req_t  req,
    output wlrs_pkg::status_t   st_q,
    output wlrs_pkg::word_t     dt_q
);

    logic [wlrs_pkg::DEPTH-1:0] valid_reg;
    logic [wlrs_pkg::DEPTH-1:0] valid_next;
    logic                       st_vld_reg;
    logic                       dt_vld_reg;
    wlrs_pkg::status_t          st_raw;
    wlrs_pkg::word_t            dt_raw;

    wlrs_ram #(
        .WIDTH (wlrs_pkg::STATUS_W),
        .DEPTH (wlrs_pkg::DEPTH)
    ) u_status_ram (
        .clk   (clk),
        .we    (req.we),
        .waddr (req.waddr),
        .wdata (req.wstatus),
        .re    (req.st_re),
        .raddr (req.st_raddr),
        .rdata (st_raw)
    );

    wlrs_ram #(
        .WIDTH (wlrs_pkg::DATA_WIDTH),
        .DEPTH (wlrs_pkg::DEPTH)
    ) u_data_ram (
        .clk   (clk),
        .we    (req.we),
        .waddr (req.waddr),
        .wdata (req.wdata),
        .re    (req.dt_re),
        .raddr (req.dt_raddr),
        .rdata (dt_raw)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (req.we)
        begin
            valid_next[req.waddr] = 1'b1;
        end
    end

    // valid flag is sampled alongside the ram read so it lines up with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            st_vld_reg <= 1'b0;
            dt_vld_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (req.st_re)
            begin
                st_vld_reg <= valid_reg[req.st_raddr];
            end
            if (req.dt_re)
            begin
                dt_vld_reg <= valid_reg[req.dt_raddr];
            end
        end
    end

    assign st_q = st_vld_reg ? st_raw : '0;
    assign dt_q = dt_vld_reg ? dt_raw : '0;

endmodule

### design/wlrs_ctrl.sv
// request sequencer: scans the status ring, writes or reads the slot, holds the result
// depends on wlrs_pkg, the channel interfaces and the assertion macros
`include "wear_level_ring_store_top_macros.svh"

module wlrs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    wlrs_req_if.sink            req,
    wlrs_rsp_if.source          rsp,
    input  wlrs_pkg::cnt_t      n_slots,
    output wlrs_pkg::mem_req_t  mem,
    input  wlrs_pkg::status_t   st_q,
    input  wlrs_pkg::word_t     dt_q
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FIRST = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_FIN   = 3'd3;
    localparam logic [2:0] ST_RDAT  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]            state_reg,  state_next;
    logic                  cmd_reg,    cmd_next;
    wlrs_pkg::word_t       wdata_reg,  wdata_next;
    wlrs_pkg::cnt_t        n_reg,      n_next;
    wlrs_pkg::slot_t       idx_reg,    idx_next;
    wlrs_pkg::status_t     prev_reg,   prev_next;
    wlrs_pkg::slot_t       ws_reg,     ws_next;
    wlrs_pkg::slot_t       ps_reg,     ps_next;
    wlrs_pkg::status_t     psval_reg,  psval_next;
    wlrs_pkg::out_data_t   res_data_reg, res_data_next;
    wlrs_pkg::out_slot_t   res_slot_reg, res_slot_next;
    logic                  out_vld_reg, out_vld_next;
    wlrs_pkg::out_data_t   out_data_reg, out_data_next;
    wlrs_pkg::out_slot_t   out_slot_reg, out_slot_next;

    logic                  accept;
    wlrs_pkg::slot_t       last_slot;
    wlrs_pkg::status_t     expect_st;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign last_slot = wlrs_pkg::slot_t'(n_reg - 1'b1);
    assign expect_st = wlrs_pkg::status_t'(prev_reg + 1'b1);

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        wdata_next    = wdata_reg;
        n_next        = n_reg;
        idx_next      = idx_reg;
        prev_next     = prev_reg;
        ws_next       = ws_reg;
        ps_next       = ps_reg;
        psval_next    = psval_reg;
        res_data_next = res_data_reg;
        res_slot_next = res_slot_reg;
        out_vld_next  = out_vld_reg;
        out_data_next = out_data_reg;
        out_slot_next = out_slot_reg;
        mem           = '0;

        if (rsp.valid && rsp.ready)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next     = req.cmd;
                    wdata_next   = wlrs_pkg::word_t'(req.write_data);
                    n_next       = n_slots;
                    // predecessor of slot 0 is the last slot in use
                    mem.st_re    = 1'b1;
                    mem.st_raddr = wlrs_pkg::slot_t'(n_slots - 1'b1);
                    state_next   = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                prev_next    = st_q;
                idx_next     = '0;
                mem.st_re    = 1'b1;
                mem.st_raddr = '0;
                state_next   = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (st_q != expect_st)
                begin
                    ws_next    = idx_reg;
                    ps_next    = (idx_reg == '0) ? last_slot
                                 : wlrs_pkg::slot_t'(idx_reg - 1'b1);
                    psval_next = prev_reg;
                    state_next = ST_FIN;
                end
                else if (idx_reg == last_slot)
                begin
                    // whole ring continues the sequence: fall back to slot 0
                    ws_next    = '0;
                    ps_next    = last_slot;
                    psval_next = st_q;
                    state_next = ST_FIN;
                end
                else
                begin
                    prev_next    = st_q;
                    idx_next     = wlrs_pkg::slot_t'(idx_reg + 1'b1);
                    mem.st_re    = 1'b1;
                    mem.st_raddr = wlrs_pkg::slot_t'(idx_reg + 1'b1);
                end
            end
            ST_FIN:
            begin
                if (cmd_reg == wlrs_pkg::CMD_WRITE)
                begin
                    mem.we        = 1'b1;
                    mem.waddr     = ws_reg;
                    mem.wstatus   = wlrs_pkg::status_t'(psval_reg + 1'b1);
                    mem.wdata     = wdata_reg;
                    res_data_next = '0;
                    res_slot_next = wlrs_pkg::out_slot_t'(ws_reg);
                    state_next    = ST_DONE;
                end
                else
                begin
                    mem.dt_re    = 1'b1;
                    mem.dt_raddr = ps_reg;
                    state_next   = ST_RDAT;
                end
            end
            ST_RDAT:
            begin
                res_data_next = wlrs_pkg::out_data_t'(dt_q);
                res_slot_next = wlrs_pkg::out_slot_t'(ps_reg);
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                // wait for the output register to drain
                if (!out_vld_reg || rsp.ready)
                begin
                    out_vld_next  = 1'b1;
                    out_data_next = res_data_reg;
                    out_slot_next = res_slot_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        wdata_reg    <= wdata_next;
        n_reg        <= n_next;
        idx_reg      <= idx_next;
        prev_reg     <= prev_next;
        ws_reg       <= ws_next;
        ps_reg       <= ps_next;
        psval_reg    <= psval_next;
        res_data_reg <= res_data_next;
        res_slot_reg <= res_slot_next;
        out_data_reg <= out_data_next;
        out_slot_reg <= out_slot_next;
    end

    assign rsp.valid     = out_vld_reg;
    assign rsp.read_data = out_data_reg;
    assign rsp.slot      = out_slot_reg;

    `WLRS_ASSERT_IMP(a_write_only_at_fin, mem.we, (state_reg == ST_FIN) && (cmd_reg == wlrs_pkg::CMD_WRITE), "ring write outside the write step")
    `WLRS_ASSERT_IMP(a_scan_in_range, state_reg == ST_SCAN, idx_reg < n_reg, "scan index past the slots in use")
    `WLRS_ASSERT_IMP(a_slots_in_range, state_reg == ST_FIN, (ws_reg < n_reg) && (ps_reg < n_reg), "chosen slot past the slots in use")
    `WLRS_ASSERT_NXT(a_accept_starts_scan, accept, (state_reg == ST_FIRST) && !mem.we, "accepted request did not start a scan")

endmodule

### design/wear_level_ring_store_top.sv
// Wear-levelled ring store: a ring of data words with a parallel ring of status
// bytes, kept in on-chip ram and cleared at reset through per-slot valid bits.
// Channels: req (cmd, write_data) and rsp (read_data, slot), valid/ready each;
// a transfer happens on a clock edge with valid and ready both high.
// cfg_we/cfg_data write slots_in_use (reset 16, zero acts as one, saturates at 16).
// Write it only while no request is in flight.
// Every request scans the status ring from slot 0 for the first break in the
// plus-one sequence, reading one status byte per cycle from the status ram.
// One request is handled at a time.
// req.ready is high only when the sequencer is idle. The result sits in an
// output register, so a new request is taken while rsp is stalled; that
// request finishes its ring update and then waits until the register drains.
// Reset empties both rings and the output register at once.
// depends on wlrs_pkg, wlrs_req_if, wlrs_rsp_if, wlrs_store and wlrs_ctrl
module wear_level_ring_store_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  wlrs_pkg::cfg_t    cfg_data,
    wlrs_req_if.sink          req,
    wlrs_rsp_if.source        rsp
);

    wlrs_pkg::cfg_t      slots_reg;
    wlrs_pkg::cnt_t      n_slots;
    wlrs_pkg::mem_req_t  mem;
    wlrs_pkg::status_t   st_q;
    wlrs_pkg::word_t     dt_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= wlrs_pkg::cfg_t'(wlrs_pkg::SLOTS_RESET);
        end
        else if (cfg_we)
        begin
            slots_reg <= cfg_data;
        end
    end

    assign n_slots = wlrs_pkg::active_slots(slots_reg);

    wlrs_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem),
        .st_q  (st_q),
        .dt_q  (dt_q)
    );

    wlrs_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .n_slots (n_slots),
        .mem     (mem),
        .st_q    (st_q),
        .dt_q    (dt_q)
    );

endmodule
